@@ hw/rtl/adts_fs_pkg.sv @@
package adts_fs_pkg;

  localparam int HEADER_BYTES = 6;
  localparam int LEN_W        = 13;
  localparam int SCAN_W       = 16;
  localparam int FILL_W       = 3;
  localparam int QUEUE_DEPTH  = 8;
  localparam int QPTR_W       = 3;
  localparam int QCNT_W       = 4;

  localparam logic [SCAN_W-1:0] MAX_SCAN_RESET = 16'd32768;
  localparam logic [SCAN_W-1:0] SCAN_SAT       = 16'hFFFF;
  localparam logic [7:0]        SYNC_BYTE      = 8'hFF;
  localparam logic [7:0]        SYNC_NIBBLE    = 8'hF0;
  localparam logic [7:0]        LAYER_MASK     = 8'h06;
  localparam logic [LEN_W-1:0]  MIN_LENGTH     = 13'd7;

  localparam logic [1:0] KIND_PASS = 2'd0;
  localparam logic [1:0] KIND_HDR  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // bytes[0] is the first header byte; a passed byte sits in bytes[0]
  typedef struct packed {
    logic [1:0]                   kind;
    logic                         last;
    logic [LEN_W-1:0]             length;
    logic [HEADER_BYTES-1:0][7:0] bytes;
  } cmd_t;

endpackage

@@ hw/rtl/adts_fs_front.sv @@
module adts_fs_front
  import adts_fs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic [SCAN_W-1:0] max_scan,
  output logic              cmd_valid,
  output cmd_t              cmd
);

  logic [7:0]        win [HEADER_BYTES];
  logic [7:0]        cand [HEADER_BYTES];
  logic [FILL_W-1:0] fill;
  logic              in_frame;
  logic [LEN_W-1:0]  remaining;
  logic [LEN_W-1:0]  cur_length;
  logic [SCAN_W-1:0] scan_count;

  logic              testing;
  logic              match;
  logic [LEN_W-1:0]  hdr_len;
  logic [SCAN_W-1:0] scan_next;
  logic              scan_hit;
  logic              last_byte;

  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (fill == FILL_W'(HEADER_BYTES)) begin
        cand[i] = (i == HEADER_BYTES - 1) ? data_byte : win[(i + 1) % HEADER_BYTES];
      end else begin
        cand[i] = (fill == FILL_W'(i)) ? data_byte : win[i];
      end
    end
  end

  assign testing   = (fill >= FILL_W'(HEADER_BYTES - 1));
  assign hdr_len   = {cand[3][1:0], cand[4], cand[5][7:5]};
  assign match     = testing && (cand[0] == SYNC_BYTE)
                     && ((cand[1] & SYNC_NIBBLE) == SYNC_NIBBLE)
                     && ((cand[1] & LAYER_MASK) == 8'h00)
                     && (hdr_len >= MIN_LENGTH);
  assign scan_next = (scan_count < SCAN_SAT) ? scan_count + 16'd1 : scan_count;
  assign scan_hit  = testing && !match && (scan_next >= max_scan);
  assign last_byte = (remaining <= 13'd1);

  always_comb begin
    cmd_valid = accept && (in_frame || match || scan_hit);
    cmd       = '0;
    if (in_frame) begin
      cmd.kind     = KIND_PASS;
      cmd.last     = last_byte;
      cmd.length   = cur_length;
      cmd.bytes[0] = data_byte;
    end else if (match) begin
      cmd.kind   = KIND_HDR;
      cmd.length = hdr_len;
      for (int i = 0; i < HEADER_BYTES; i++) begin
        cmd.bytes[i] = cand[i];
      end
    end else begin
      cmd.kind = KIND_ERR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      in_frame   <= 1'b0;
      remaining  <= '0;
      cur_length <= '0;
      scan_count <= '0;
      for (int i = 0; i < HEADER_BYTES; i++) begin
        win[i] <= '0;
      end
    end else if (accept) begin
      if (in_frame) begin
        if (last_byte) begin
          remaining <= '0;
          in_frame  <= 1'b0;
          fill      <= '0;
        end else begin
          remaining <= remaining - 13'd1;
        end
      end else begin
        for (int i = 0; i < HEADER_BYTES; i++) begin
          win[i] <= cand[i];
        end
        if (match) begin
          cur_length <= hdr_len;
          remaining  <= hdr_len - LEN_W'(HEADER_BYTES);
          in_frame   <= 1'b1;
          fill       <= '0;
          scan_count <= '0;
        end else begin
          if (!testing) begin
            fill <= fill + 3'd1;
          end else begin
            fill       <= FILL_W'(HEADER_BYTES);
            scan_count <= scan_hit ? '0 : scan_next;
          end
        end
      end
    end
  end

endmodule

@@ hw/rtl/adts_fs_queue.sv @@
module adts_fs_queue
  import adts_fs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_cmd,
  input  logic rd,
  output cmd_t rd_cmd,
  output logic empty,
  output logic full
);

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty  = (count == '0);
  assign full   = (count == QCNT_W'(QUEUE_DEPTH));
  assign rd_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (wr && !rd) begin
        count <= count + QCNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/adts_fs_back.sv @@
module adts_fs_back
  import adts_fs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  cmd_t        q_cmd,
  output logic        q_rd,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  cmd_t              cur;
  logic              cur_valid;
  logic [FILL_W-1:0] idx;
  logic              load;
  logic              done;

  assign load = cur_valid && (!m_tvalid || m_tready);
  assign done = load && ((cur.kind != KIND_HDR) || (idx == FILL_W'(HEADER_BYTES - 1)));
  assign q_rd = !q_empty && (!cur_valid || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_rd) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (done) begin
      cur_valid <= 1'b0;
    end else if (load) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unique case (cur.kind)
        KIND_PASS: begin
          m_tdata <= {3'b000, cur.length, cur.bytes[0]};
          m_tuser <= 2'b00;
          m_tlast <= cur.last;
        end
        KIND_HDR: begin
          m_tdata <= {3'b000, cur.length, cur.bytes[idx]};
          m_tuser <= {1'b0, (idx == '0)};
          m_tlast <= 1'b0;
        end
        default: begin
          m_tdata <= '0;
          m_tuser <= 2'b10;
          m_tlast <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/adts_frame_sync.sv @@
// Path: an accepted s_* byte goes via the command queue and current-command register to m_*.
// Throughput: one byte per cycle in if the queue has room; one beat per cycle out if m_tready.
// A header match yields six beats from one byte; the eight-entry command queue absorbs it.
// Reset (rst, synchronous): hunt state, window, counters and queue cleared; max_scan to 32768.
module adts_frame_sync
  import adts_fs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] out_byte, [20:8] frame_length, [23:21] zero
  output logic [1:0]  m_tuser,   // [0] first_of_frame, [1] sync_error
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [SCAN_W-1:0] max_scan;
  logic              accept;
  logic              f_valid;
  cmd_t              f_cmd;
  cmd_t              q_cmd;
  logic              q_rd;
  logic              q_empty;
  logic              q_full;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == 1'b0) ? {16'h0000, max_scan} : 32'h0000_0000;
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_scan <= MAX_SCAN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      max_scan <= pwdata[SCAN_W-1:0];
    end
  end

  adts_fs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .max_scan  (max_scan),
    .cmd_valid (f_valid),
    .cmd       (f_cmd)
  );

  adts_fs_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (f_valid),
    .wr_cmd (f_cmd),
    .rd     (q_rd),
    .rd_cmd (q_cmd),
    .empty  (q_empty),
    .full   (q_full)
  );

  adts_fs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_cmd    (q_cmd),
    .q_rd     (q_rd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
